[src/prat_pkg.sv]
package prat_pkg;

    localparam int NUM_REGIONS_DEF = 8;
    localparam int MAX_CHUNKS      = 8;
    localparam int CNT_W           = $clog2(MAX_CHUNKS + 1);
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);

    localparam int ADDR_W = 64;
    localparam int LEN_W  = 32;
    localparam int IDX_W  = 3;
    localparam int STAT_W = 2;

    localparam logic FUNC_PROGRAM   = 1'b0;
    localparam logic FUNC_TRANSLATE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOREGION = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADMODE  = 2'd2;

    typedef struct packed {
        logic              is_prog;
        logic [IDX_W-1:0]  region_index;
        logic              region_enable;
        logic              region_match_mode;
        logic [ADDR_W-1:0] region_limit;
        logic [ADDR_W-1:0] region_delta;
        logic [ADDR_W-1:0] host_address;
        logic [LEN_W-1:0]  access_length;
    } t_entry;

endpackage

[src/prat_queue.sv]
module prat_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  prat_pkg::t_entry i_entry,
    input  logic            i_pop,
    output prat_pkg::t_entry o_entry,
    output logic            o_empty,
    output logic            o_full
);

    prat_pkg::t_entry                r_mem [prat_pkg::Q_DEPTH];
    logic [prat_pkg::Q_PTR_W-1:0]    r_wp;
    logic [prat_pkg::Q_PTR_W-1:0]    r_rp;
    logic [prat_pkg::Q_PTR_W:0]      r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (prat_pkg::Q_PTR_W + 1)'(prat_pkg::Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= prat_pkg::Q_PTR_W'(r_wp + 1'b1);
            end
            if (do_pop) begin
                r_rp <= prat_pkg::Q_PTR_W'(r_rp + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/prat_front.sv]
module prat_front #(
    parameter int NUM_REGIONS = prat_pkg::NUM_REGIONS_DEF
) (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [prat_pkg::IDX_W-1:0]    i_region_index,
    input  logic                          i_region_enable,
    input  logic                          i_region_match_mode,
    input  logic [prat_pkg::ADDR_W-1:0]   i_region_base,
    input  logic [prat_pkg::ADDR_W-1:0]   i_region_limit,
    input  logic [prat_pkg::ADDR_W-1:0]   i_region_target,
    input  logic [prat_pkg::ADDR_W-1:0]   i_host_address,
    input  logic [prat_pkg::LEN_W-1:0]    i_access_length,
    input  logic                          i_q_full,
    output logic                          o_push,
    output prat_pkg::t_entry              o_entry
);

    logic idx_ok;
    logic is_prog;

    assign is_prog = (i_func == prat_pkg::FUNC_PROGRAM);
    assign idx_ok  = ({{(32 - prat_pkg::IDX_W){1'b0}}, i_region_index} < 32'(NUM_REGIONS));
    assign o_ready = !i_q_full;
    // drop program items aimed beyond the table
    assign o_push  = i_valid && !i_q_full && (!is_prog || idx_ok);

    always_comb begin
        o_entry.is_prog           = is_prog;
        o_entry.region_index      = i_region_index;
        o_entry.region_enable     = i_region_enable;
        o_entry.region_match_mode = i_region_match_mode;
        o_entry.region_limit      = i_region_limit;
        o_entry.region_delta      = i_region_target - i_region_base;
        // carry the region base in the address field of a program item
        o_entry.host_address      = is_prog ? i_region_base : i_host_address;
        o_entry.access_length     = i_access_length;
    end

endmodule

[src/prat_back.sv]
module prat_back #(
    parameter int NUM_REGIONS = prat_pkg::NUM_REGIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prat_pkg::t_entry              i_entry,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [prat_pkg::ADDR_W-1:0]   o_device_address,
    output logic [prat_pkg::LEN_W-1:0]    o_chunk_length,
    output logic [prat_pkg::STAT_W-1:0]   o_status,
    output logic                          o_last
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CHUNK} t_state;

    t_state                          r_state;
    logic                            r_en    [NUM_REGIONS];
    logic                            r_mode  [NUM_REGIONS];
    logic [prat_pkg::ADDR_W-1:0]     r_base  [NUM_REGIONS];
    logic [prat_pkg::ADDR_W-1:0]     r_limit [NUM_REGIONS];
    logic [prat_pkg::ADDR_W-1:0]     r_delta [NUM_REGIONS];

    logic [prat_pkg::ADDR_W-1:0]     r_addr;
    logic [prat_pkg::LEN_W-1:0]      r_rem;
    logic [prat_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_found;
    logic                            r_hit_mode;
    logic [prat_pkg::ADDR_W-1:0]     r_hit_limit;
    logic [prat_pkg::ADDR_W-1:0]     r_hit_delta;

    logic                            r_o_valid;
    logic [prat_pkg::ADDR_W-1:0]     r_dev;
    logic [prat_pkg::LEN_W-1:0]      r_len;
    logic [prat_pkg::STAT_W-1:0]     r_status;
    logic                            r_last;

    logic                            n_found;
    logic                            n_hit_mode;
    logic [prat_pkg::ADDR_W-1:0]     n_hit_limit;
    logic [prat_pkg::ADDR_W-1:0]     n_hit_delta;
    logic [prat_pkg::ADDR_W-1:0]     span;
    logic [prat_pkg::LEN_W-1:0]      rem_m1;
    logic                            take_all;
    logic [prat_pkg::LEN_W-1:0]      chunk;
    logic                            out_free;

    assign o_pop            = (r_state == S_IDLE) && !i_q_empty;
    assign out_free         = !r_o_valid || i_ready;
    assign o_valid          = r_o_valid;
    assign o_device_address = r_dev;
    assign o_chunk_length   = r_len;
    assign o_status         = r_status;
    assign o_last           = r_last;

    always_comb begin
        n_found     = 1'b0;
        n_hit_mode  = 1'b0;
        n_hit_limit = '0;
        n_hit_delta = '0;
        for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
            if (r_en[i] && (r_mode[i] || (r_addr >= r_base[i] && r_addr <= r_limit[i]))) begin
                n_found     = 1'b1;
                n_hit_mode  = r_mode[i];
                n_hit_limit = r_limit[i];
                n_hit_delta = r_delta[i];
            end
        end
    end

    assign span     = r_hit_limit - r_addr;
    assign rem_m1   = r_rem - 1'b1;
    assign take_all = (span[63:32] != '0) || (span[31:0] >= rem_m1);
    assign chunk    = take_all ? r_rem : span[31:0] + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_en[i] <= 1'b0;
            end
        end else begin
            if ((r_state == S_CHUNK) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_entry.is_prog) begin
                            for (int i = 0; i < NUM_REGIONS; i++) begin
                                if ({{(32 - prat_pkg::IDX_W){1'b0}}, i_entry.region_index}
                                        == 32'(i)) begin
                                    r_en[i]    <= i_entry.region_enable;
                                    r_mode[i]  <= i_entry.region_match_mode;
                                    r_base[i]  <= i_entry.host_address;
                                    r_limit[i] <= i_entry.region_limit;
                                    r_delta[i] <= i_entry.region_delta;
                                end
                            end
                        end else begin
                            r_addr  <= i_entry.host_address;
                            r_rem   <= i_entry.access_length;
                            r_cnt   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_found     <= n_found;
                    r_hit_mode  <= n_hit_mode;
                    r_hit_limit <= n_hit_limit;
                    r_hit_delta <= n_hit_delta;
                    r_state     <= S_CHUNK;
                end
                S_CHUNK: begin
                    if (out_free) begin
                        if (r_rem == '0) begin
                            r_dev    <= '0;
                            r_len    <= '0;
                            r_status <= prat_pkg::ST_OK;
                            r_last   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if ((r_cnt == prat_pkg::CNT_W'(prat_pkg::MAX_CHUNKS))
                                     || !r_found) begin
                            r_dev    <= '0;
                            r_len    <= '0;
                            r_status <= prat_pkg::ST_NOREGION;
                            r_last   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (r_hit_mode) begin
                            r_dev    <= '0;
                            r_len    <= '0;
                            r_status <= prat_pkg::ST_BADMODE;
                            r_last   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_dev    <= r_addr + r_hit_delta;
                            r_len    <= chunk;
                            r_status <= prat_pkg::ST_OK;
                            r_last   <= take_all;
                            if (take_all) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_addr  <= r_addr + {{(prat_pkg::ADDR_W - prat_pkg::LEN_W){1'b0}},
                                                     chunk};
                                r_rem   <= r_rem - chunk;
                                r_cnt   <= r_cnt + 1'b1;
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/pcie_region_address_translate.sv]
// Address translation over a table of host address regions.
// Input channel (i_valid/o_ready) takes program items (i_func 0), which
// write one region slot, and translate items (i_func 1), which give a
// host address and byte length. Output channel (o_valid/i_ready) gives
// one result per translated chunk; o_last marks the final result of an
// item. Program items give no result.
// Items pass through a two-entry queue to the walk engine, so the input
// side keeps accepting while a result waits on the output register.
// A translate item leaves the queue in S_IDLE, its region compare is
// registered in S_SCAN, and S_CHUNK does the chunk arithmetic and loads
// the output register; each further chunk passes S_SCAN (parallel region
// compare) and S_CHUNK (chunk arithmetic) again. A program item is
// written to the table in S_IDLE. The engine takes no new item until it
// has finished the current one and is back in S_IDLE.
// When the receiver stalls, the engine holds its next result and stops;
// the queue then fills and o_ready drops.
// Reset disables all regions and empties queue and output register.
module pcie_region_address_translate #(
    parameter int NUM_REGIONS = prat_pkg::NUM_REGIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [prat_pkg::IDX_W-1:0]    i_region_index,
    input  logic                          i_region_enable,
    input  logic                          i_region_match_mode,
    input  logic [prat_pkg::ADDR_W-1:0]   i_region_base,
    input  logic [prat_pkg::ADDR_W-1:0]   i_region_limit,
    input  logic [prat_pkg::ADDR_W-1:0]   i_region_target,
    input  logic [prat_pkg::ADDR_W-1:0]   i_host_address,
    input  logic [prat_pkg::LEN_W-1:0]    i_access_length,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [prat_pkg::ADDR_W-1:0]   o_device_address,
    output logic [prat_pkg::LEN_W-1:0]    o_chunk_length,
    output logic [prat_pkg::STAT_W-1:0]   o_status,
    output logic                          o_last
);

    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    prat_pkg::t_entry q_in;
    prat_pkg::t_entry q_out;

    prat_front #(
        .NUM_REGIONS(NUM_REGIONS)
    ) u_front (
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_func              (i_func),
        .i_region_index      (i_region_index),
        .i_region_enable     (i_region_enable),
        .i_region_match_mode (i_region_match_mode),
        .i_region_base       (i_region_base),
        .i_region_limit      (i_region_limit),
        .i_region_target     (i_region_target),
        .i_host_address      (i_host_address),
        .i_access_length     (i_access_length),
        .i_q_full            (q_full),
        .o_push              (q_push),
        .o_entry             (q_in)
    );

    prat_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    prat_back #(
        .NUM_REGIONS(NUM_REGIONS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_entry          (q_out),
        .i_q_empty        (q_empty),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_device_address (o_device_address),
        .o_chunk_length   (o_chunk_length),
        .o_status         (o_status),
        .o_last           (o_last)
    );

endmodule
